@@ src/assert_macros.svh @@
// Assertion macros used by the checker file spa_checker.sv.
// Each macro expects clk to be visible where it is used; SPA_ASSERT_IMPL also expects rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define SPA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/spa_pkg.sv @@
// Package for the superpixel pixel assignment block.
// Holds payload structs, configuration codes and fixed widths; no dependencies.
package spa_pkg;

  localparam int IMAGE_WIDTH_DEF  = 512;
  localparam int IMAGE_HEIGHT_DEF = 512;
  localparam int MAX_CLUSTERS_DEF = 1024;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_INV_M = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_S = 1'b1;
  localparam logic [15:0] INV_M_RESET = 16'd6554;
  localparam logic [15:0] INV_S_RESET = 16'd4096;

  localparam int DIST_W  = 18;
  localparam int LABEL_W = 10;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Square root unit: 28-bit radicand, 14 result bits, one bit per stage.
  localparam int ROOT_IN_W  = 28;
  localparam int ROOT_W     = 14;
  localparam int ROOT_STEPS = 14;
  localparam int ROOT_LAT   = ROOT_STEPS + 1;

  typedef struct packed {
    logic       action;
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
    logic [7:0] pixel_l;
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic [8:0] center_x;
    logic [8:0] center_y;
    logic [7:0] center_l;
    logic [7:0] center_a;
    logic [7:0] center_b;
    logic [9:0] cluster_index;
  } in_t;

  typedef struct packed {
    logic               assigned;
    logic [LABEL_W-1:0] pixel_label;
    logic               label_changed;
    logic [DIST_W-1:0]  best_distance_out;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [LABEL_W-1:0] label;
    logic [DIST_W-1:0]  best;
  } ent_t;

  localparam ent_t ENT_RESET = '{valid: 1'b0, label: '0, best: DIST_MAX};

endpackage

@@ src/spa_root.sv @@
// Pipelined integer square root, rounded to nearest, one result bit per stage.
// Depends on spa_pkg for widths; step registers followed by a rounding register, advancing on en.
module spa_root import spa_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ROOT_IN_W-1:0] radicand,
  output logic [ROOT_W-1:0]    root
);

  logic [ROOT_IN_W-1:0] rem_q [ROOT_STEPS];
  logic [ROOT_IN_W-1:0] acc_q [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [ROOT_IN_W:0] BIT = (ROOT_IN_W+1)'(1) << (ROOT_IN_W - 2 - 2*k);
    logic [ROOT_IN_W-1:0] rem_in;
    logic [ROOT_IN_W-1:0] acc_in;
    logic [ROOT_IN_W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign acc_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign acc_in = acc_q[k-1];
    end

    assign trial = {1'b0, acc_in} + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[k] <= ROOT_IN_W'({1'b0, rem_in} - trial);
          acc_q[k] <= ROOT_IN_W'({1'b0, acc_in >> 1} + BIT);
        end else begin
          rem_q[k] <= rem_in;
          acc_q[k] <= acc_in >> 1;
        end
      end
    end
  end

  // The remainder left is v - r*r; round up when it exceeds r.
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_q[ROOT_STEPS-1] > acc_q[ROOT_STEPS-1]) begin
        root <= ROOT_W'(acc_q[ROOT_STEPS-1] + ROOT_IN_W'(1));
      end else begin
        root <= ROOT_W'(acc_q[ROOT_STEPS-1]);
      end
    end
  end

endmodule

@@ src/superpixel_pixel_assign.sv @@
// Superpixel pixel assignment: one pixel/center pair per word in, one result word out.
// The input word carries action, pixel and center coordinates and Lab colour, and the
// cluster index; the output word reports the pixel's entry after the step.
// Both channels are valid/ready. cfg_we writes inv_m (index 0) or inv_s (index 1)
// and must only be used while the block is idle.
// Throughput is one word per cycle while the receiver takes results and no clearing
// pass runs. From input acceptance to output valid a word passes one input stage, one
// stage of squared sums, the square root pipelines, a multiply stage, and the distance
// stage, which also receives the entry read from the per-pixel memory; the result register follows.
// The per-pixel store is one memory of IMAGE_WIDTH*IMAGE_HEIGHT entries with one write
// and one read port; a write to the entry just read is forwarded.
// After reset a clearing pass writes every entry, one per cycle; in_ready stays low
// meanwhile.
// When the receiver stalls, the whole pipeline holds and in_ready drops.
module superpixel_pixel_assign import spa_pkg::*; #(
  parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ENT_W  = $bits(ent_t);
  localparam int NST    = ROOT_LAT + 4;
  localparam int RD_ST  = NST - 2;
  localparam int CMP_ST = NST - 1;

  typedef struct packed {
    logic               valid;
    logic               action;
    logic               inrange;
    logic               ci_ok;
    logic [ADDR_W-1:0]  addr;
    logic [LABEL_W-1:0] label;
  } ctl_t;

  logic [15:0] inv_m;
  logic [15:0] inv_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_m <= INV_M_RESET;
      inv_s <= INV_S_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_M: inv_m <= cfg_data;
        REG_INV_S: inv_s <= cfg_data;
        default: ;
      endcase
    end
  end

  logic              clearing;
  logic [ADDR_W-1:0] clr_cnt;
  logic              adv;
  logic              accept;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clearing;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
      if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Control travels alongside the datapath, one entry per stage.
  ctl_t ctl [NST];
  ctl_t ctl_in;
  in_t  in_q;

  always_comb begin
    ctl_in.valid   = accept;
    ctl_in.action  = in_data.action;
    ctl_in.inrange = (32'(in_data.pixel_x) < 32'(IMAGE_WIDTH)) &&
                     (32'(in_data.pixel_y) < 32'(IMAGE_HEIGHT));
    ctl_in.ci_ok   = 32'(in_data.cluster_index) < 32'(MAX_CLUSTERS);
    ctl_in.addr    = ADDR_W'(32'(in_data.pixel_y) * 32'(IMAGE_WIDTH) + 32'(in_data.pixel_x));
    ctl_in.label   = in_data.cluster_index;
  end

  for (genvar s = 0; s < NST; s++) begin : g_ctl
    if (s == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl[s].valid <= 1'b0;
        end else if (adv) begin
          ctl[s] <= ctl_in;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl[s].valid <= 1'b0;
        end else if (adv) begin
          ctl[s] <= ctl[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_data;
    end
  end

  // Squared differences.
  logic [7:0]  dl, da, db;
  logic [8:0]  dx, dy;
  logic [17:0] csum;
  logic [18:0] ssum;

  always_comb begin
    dl = (in_q.pixel_l >= in_q.center_l) ? in_q.pixel_l - in_q.center_l
                                         : in_q.center_l - in_q.pixel_l;
    da = (in_q.pixel_a >= in_q.center_a) ? in_q.pixel_a - in_q.center_a
                                         : in_q.center_a - in_q.pixel_a;
    db = (in_q.pixel_b >= in_q.center_b) ? in_q.pixel_b - in_q.center_b
                                         : in_q.center_b - in_q.pixel_b;
    dx = (in_q.pixel_x >= in_q.center_x) ? in_q.pixel_x - in_q.center_x
                                         : in_q.center_x - in_q.pixel_x;
    dy = (in_q.pixel_y >= in_q.center_y) ? in_q.pixel_y - in_q.center_y
                                         : in_q.center_y - in_q.pixel_y;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      csum <= 18'(16'(dl) * 16'(dl)) + 18'(16'(da) * 16'(da)) + 18'(16'(db) * 16'(db));
      ssum <= 19'(18'(dx) * 18'(dx)) + 19'(18'(dy) * 18'(dy));
    end
  end

  logic [ROOT_W-1:0] dc, ds;

  spa_root u_root_col (
    .clk      (clk),
    .en       (adv),
    .radicand (ROOT_IN_W'({csum, 8'd0})),
    .root     (dc)
  );

  spa_root u_root_spa (
    .clk      (clk),
    .en       (adv),
    .radicand (ROOT_IN_W'({ssum, 8'd0})),
    .root     (ds)
  );

  logic [29:0] prod_c, prod_s;
  logic [30:0] dsum;
  logic [DIST_W-1:0] new_dist;

  assign dsum = 31'(prod_c) + 31'(prod_s) + 31'd2048;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_c   <= 30'(dc) * 30'(inv_m);
      prod_s   <= 30'(ds) * 30'(inv_s);
      new_dist <= (dsum[30:12] > 19'(DIST_MAX)) ? DIST_MAX : DIST_W'(dsum[30:12]);
    end
  end

  // Per-pixel memory, read-first, with forwarding of the write issued in the
  // same cycle as the read.
  logic [ENT_W-1:0]  mem [DEPTH];
  logic [ENT_W-1:0]  mem_q;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  ent_t              wr_ent;
  logic              fwd_hit;
  ent_t              fwd_ent;
  logic              upd_en;
  ent_t              cur, upd;
  logic              changed;

  always_comb begin
    cur     = fwd_hit ? fwd_ent : ent_t'(mem_q);
    upd     = cur;
    upd_en  = 1'b0;
    changed = 1'b0;
    if (ctl[CMP_ST].action) begin
      upd    = ENT_RESET;
      upd_en = 1'b1;
    end else if (ctl[CMP_ST].ci_ok && new_dist < cur.best) begin
      upd.valid = 1'b1;
      upd.label = ctl[CMP_ST].label;
      upd.best  = new_dist;
      upd_en    = 1'b1;
      changed   = 1'b1;
    end
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_ent  = ENT_RESET;
    end else begin
      wr_en   = adv && ctl[CMP_ST].valid && ctl[CMP_ST].inrange && upd_en;
      wr_addr = ctl[CMP_ST].addr;
      wr_ent  = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_ent;
    end
    if (adv) begin
      mem_q   <= mem[ctl[RD_ST].addr];
      fwd_hit <= wr_en && (wr_addr == ctl[RD_ST].addr);
      fwd_ent <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl[CMP_ST].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl[CMP_ST].valid) begin
      if (ctl[CMP_ST].inrange) begin
        out_data.assigned          <= upd.valid;
        out_data.pixel_label       <= upd.label;
        out_data.label_changed     <= changed;
        out_data.best_distance_out <= upd.best;
      end else begin
        out_data.assigned          <= 1'b0;
        out_data.pixel_label       <= '0;
        out_data.label_changed     <= 1'b0;
        out_data.best_distance_out <= DIST_MAX;
      end
    end
  end

endmodule

@@ src/spa_checker.sv @@
// Port-level checker for superpixel_pixel_assign, attached by bind.
// Depends on spa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spa_checker import spa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `SPA_ASSERT_NEXT(a_reset_quiet, rst, !out_valid && !in_ready)
  `SPA_ASSERT_IMPL(a_change_assigns, out_valid && out_data.label_changed, out_data.assigned)
  `SPA_ASSERT_IMPL(a_unassigned_clean, out_valid && !out_data.assigned, out_data.pixel_label == '0 && out_data.best_distance_out == DIST_MAX)
  `SPA_ASSERT_IMPL(a_assigned_below_max, out_valid && out_data.assigned, out_data.best_distance_out != DIST_MAX)
  `SPA_ASSERT_IMPL(a_stall_ready, out_valid && !out_ready, !in_ready)

endmodule

bind superpixel_pixel_assign spa_checker u_spa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/superpixel_pixel_assign_test.sv @@
// Testbench for superpixel_pixel_assign: random and directed pixel/center words,
// predicted against an in-order pixel-store predictor held in a scoreboard class.
// Depends on spa_pkg and the superpixel_pixel_assign RTL.
`timescale 1ns / 100ps

module superpixel_pixel_assign_test;
  import spa_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int DRAIN_CYCLES   = 25;

  class assign_scoreboard;
    out_t                  pending_q[$];
    logic [DIST_W-1:0]     dist_mem[int];
    logic [LABEL_W-1:0]    label_mem[int];
    bit                    taken_mem[int];
    logic [15:0]           weight_color = INV_M_RESET;
    logic [15:0]           weight_space = INV_S_RESET;
    int                    errors = 0;

    function automatic longint unsigned root_near(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int i = 14; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= v) r = t;
      end
      if (v - r * r > r) r++;
      return r;
    endfunction

    function automatic longint unsigned sq(int p, int q);
      longint unsigned d;
      d = (p >= q) ? p - q : q - p;
      return d * d;
    endfunction

    function void set_weight(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      if (idx == REG_INV_M) weight_color = val;
      else if (idx == REG_INV_S) weight_space = val;
    endfunction

    function void note_pixel(in_t w);
      int addr;
      longint unsigned csum, ssum, dcol, dspc, d;
      out_t r;
      addr = int'(w.pixel_y) * IMAGE_WIDTH_DEF + int'(w.pixel_x);
      if (!dist_mem.exists(addr)) begin
        dist_mem[addr] = DIST_MAX;
        label_mem[addr] = '0;
        taken_mem[addr] = 1'b0;
      end
      r.label_changed = 1'b0;
      if (w.action) begin
        dist_mem[addr] = DIST_MAX;
        label_mem[addr] = '0;
        taken_mem[addr] = 1'b0;
      end else if (int'(w.cluster_index) < MAX_CLUSTERS_DEF) begin
        csum = sq(w.pixel_l, w.center_l) + sq(w.pixel_a, w.center_a) +
               sq(w.pixel_b, w.center_b);
        ssum = sq(w.pixel_x, w.center_x) + sq(w.pixel_y, w.center_y);
        dcol = root_near(csum << 8);
        dspc = root_near(ssum << 8);
        d = (dcol * weight_color + dspc * weight_space + 2048) >> 12;
        if (d > DIST_MAX) d = DIST_MAX;
        if (d < dist_mem[addr]) begin
          dist_mem[addr] = d[DIST_W-1:0];
          label_mem[addr] = w.cluster_index;
          taken_mem[addr] = 1'b1;
          r.label_changed = 1'b1;
        end
      end
      r.assigned = taken_mem[addr];
      r.pixel_label = label_mem[addr];
      r.best_distance_out = dist_mem[addr];
      pending_q = {pending_q, r};
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.assigned !== want.assigned) begin
        $error("assigned: expected %0d, got %0d", want.assigned, got.assigned);
        errors++;
      end
      if (got.pixel_label !== want.pixel_label) begin
        $error("pixel_label: expected %0d, got %0d", want.pixel_label, got.pixel_label);
        errors++;
      end
      if (got.label_changed !== want.label_changed) begin
        $error("label_changed: expected %0d, got %0d", want.label_changed,
               got.label_changed);
        errors++;
      end
      if (got.best_distance_out !== want.best_distance_out) begin
        $error("best_distance_out: expected %0d, got %0d", want.best_distance_out,
               got.best_distance_out);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_INV_M;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit quiet = 1'b0;
  int idle_count = 0;
  int pool_x[16];
  int pool_y[16];
  assign_scoreboard sb = new();

  always #5 clk = ~clk;

  superpixel_pixel_assign DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // The watchdog also covers the clearing pass after reset.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("superpixel_pixel_assign verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n;
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 19);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_word(in_t w);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(w);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_weights(logic [15:0] wm, logic [15:0] ws);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_INV_M;
    cfg_data <= wm;
    sb.set_weight(REG_INV_M, wm);
    @(posedge clk);
    cfg_index <= REG_INV_S;
    cfg_data <= ws;
    sb.set_weight(REG_INV_S, ws);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int near_coord(int c);
    int v;
    v = c + $urandom_range(0, 40) - 20;
    if (v < 0) v = 0;
    if (v > 511) v = 511;
    return v;
  endfunction

  // Mostly words on a small set of pixels, so that stored distances get beaten
  // or held; the rest are words anywhere in the image, and any word may be a clear.
  function automatic in_t random_word();
    in_t w;
    int k;
    w.action = ($urandom_range(0, 11) == 0);
    if ($urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, 15);
      w.pixel_x = 9'(pool_x[k]);
      w.pixel_y = 9'(pool_y[k]);
    end else begin
      w.pixel_x = 9'($urandom_range(0, 511));
      w.pixel_y = 9'($urandom_range(0, 511));
    end
    w.pixel_l = 8'($urandom_range(0, 255));
    w.pixel_a = 8'($urandom_range(0, 255));
    w.pixel_b = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) begin
      w.center_x = 9'(near_coord(int'(w.pixel_x)));
      w.center_y = 9'(near_coord(int'(w.pixel_y)));
    end else begin
      w.center_x = 9'($urandom_range(0, 511));
      w.center_y = 9'($urandom_range(0, 511));
    end
    w.center_l = 8'($urandom_range(0, 255));
    w.center_a = 8'($urandom_range(0, 255));
    w.center_b = 8'($urandom_range(0, 255));
    w.cluster_index = 10'($urandom_range(0, 1023));
    return w;
  endfunction

  task automatic random_phase(int count);
    repeat (count) begin
      send_word(random_word());
      maybe_gap();
    end
  endtask

  function automatic in_t pair(bit act, int px, int py, int pc, int cx, int cy,
                               int cc, int idx);
    in_t w;
    w = '{act, 9'(px), 9'(py), 8'(pc), 8'(pc), 8'(pc), 9'(cx), 9'(cy),
          8'(cc), 8'(cc), 8'(cc), 10'(idx)};
    return w;
  endfunction

  initial begin
    for (int i = 0; i < 16; i++) begin
      pool_x[i] = $urandom_range(0, 511);
      pool_y[i] = $urandom_range(0, 511);
    end
    pool_x[0] = 0;   pool_y[0] = 0;
    pool_x[1] = 511; pool_y[1] = 511;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!in_ready);

    // Reset weights: exact match, repeat without change, far corners, clears.
    send_word(pair(1'b0, 0, 0, 0, 0, 0, 0, 0));
    send_word(pair(1'b0, 0, 0, 0, 0, 0, 0, 5));
    send_word(pair(1'b0, 511, 511, 255, 0, 0, 0, 1023));
    send_word(pair(1'b0, 511, 511, 255, 511, 511, 255, 7));
    send_word(pair(1'b1, 511, 511, 0, 0, 0, 0, 0));
    send_word(pair(1'b1, 100, 200, 0, 0, 0, 0, 0));
    send_word(pair(1'b0, 511, 511, 255, 500, 500, 250, 512));
    send_word(pair(1'b0, 0, 511, 0, 511, 0, 255, 1));
    send_word(pair(1'b0, 511, 0, 128, 255, 256, 127, 682));
    send_word(pair(1'b0, 511, 0, 128, 255, 256, 127, 341));
    random_phase(40);

    // Largest weights: saturated distances must never assign.
    write_weights(16'hFFFF, 16'hFFFF);
    send_word(pair(1'b0, 3, 3, 0, 511, 511, 255, 9));
    send_word(pair(1'b0, 508, 2, 255, 0, 511, 0, 10));
    send_word(pair(1'b1, 0, 0, 0, 0, 0, 0, 0));
    send_word(pair(1'b0, 0, 0, 0, 511, 511, 255, 11));
    random_phase(140);

    write_weights(16'd1, 16'd1);
    random_phase(140);

    // Zero weight on one term at a time.
    write_weights(16'd0, 16'd40000);
    random_phase(60);
    write_weights(16'd50000, 16'd0);
    random_phase(60);

    write_weights(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    random_phase(100);
    quiet = 1'b1;
    random_phase(150);

    drain();
    if (sb.errors == 0) begin
      $display("superpixel_pixel_assign verification clean");
    end else begin
      $display("superpixel_pixel_assign verification failed");
    end
    $finish;
  end

endmodule
